// ===== rtl/cpra_pkg.sv =====
// ----------------------------------------------------------------------------
// cpra_pkg
// Shared types and constants of the contiguous page-run allocator.
// ----------------------------------------------------------------------------
package cpra_pkg;

   localparam int HEAP_ENTRIES_DEF  = 4096;
   localparam int FRAME_BITS_DEF    = 65536;
   localparam int MAX_RUN_PAGES_DEF = 64;

   localparam logic [31:0] PAGE_BYTES      = 32'h0000_1000;
   localparam logic [31:0] KERNEL_LIMIT    = 32'hC000_0000;
   localparam logic [31:0] KERNEL_HEAP_LOW = 32'h8000_0000;

   localparam logic [31:0] RST_ALLOC_BASE   = 32'h8000_0000;
   localparam logic [12:0] RST_HEAP_ENTRIES = 13'd4096;
   localparam logic [16:0] RST_FRAME_COUNT  = 17'd65536;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_NULL         = 4'd1,
      ST_TOO_LARGE    = 4'd2,
      ST_NO_RUN       = 4'd3,
      ST_NO_FRAME     = 4'd4,
      ST_KERNEL       = 4'd5,
      ST_WRONG_HEAP   = 4'd6,
      ST_NO_USER_HEAP = 4'd7,
      ST_RANGE        = 4'd8,
      ST_NOT_PRESENT  = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      REG_ALLOC_BASE   = 3'd0,
      REG_USER_HEAP    = 3'd1,
      REG_HEAP_ENTRIES = 3'd2,
      REG_FRAME_COUNT  = 3'd3,
      REG_FRAME_OFFSET = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [31:0] allocation_base;
      logic        user_heap_active;
      logic [12:0] heap_entries;
      logic [16:0] frame_count;
      logic [19:0] frame_offset;
   } cfg_type;

   typedef struct packed {
      logic rd;
      logic skip;
      logic take;
   } fs_cmd_type;

   typedef struct packed {
      logic ready;
      logic full;
      logic exhausted;
   } fs_stat_type;

endpackage

// ===== rtl/cpra_if.sv =====
// ----------------------------------------------------------------------------
// cpra_req_if / cpra_rsp_if
// Request and response channels of the contiguous page-run allocator.
// ----------------------------------------------------------------------------
interface cpra_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] size_bytes;
   logic [31:0] address;

   modport source (output valid, output kind, output size_bytes, output address,
                   input ready);
   modport sink   (input valid, input kind, input size_bytes, input address,
                   output ready);
endinterface

interface cpra_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] virtual_address;
   logic [31:0] phys_address;
   logic [5:0]  page_in_run;
   logic [6:0]  pages_freed;
   logic        last;

   modport source (output valid, output status, output virtual_address,
                   output phys_address, output page_in_run, output pages_freed,
                   output last, input ready);
   modport sink   (input valid, input status, input virtual_address,
                   input phys_address, input page_in_run, input pages_freed,
                   input last, output ready);
endinterface

// ===== rtl/contiguous_page_run_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator
// First-fit allocator of contiguous 4 KB page runs backed by a frame bitmap.
//
//   channel  direction  handshake            beat
//   req      in         valid/ready          kind, size_bytes, address
//   rsp      out        valid/ready          status, addresses, page_in_run,
//                                            pages_freed, last
//   csr      in         APB, pready high     five configuration registers
//
// After reset a clearing pass over the page memory and the frame bitmap
// runs; no request is taken until it ends.
// An allocate searches the page entries for a free run, then for each page
// reads bitmap words, steps over full ones and gives a beat; a free reads
// the run length, checks each page of the run, looks up and clears the
// present ones and gives one beat.
// One item is handled at a time; a stalled rsp holds the sequencer.
// ----------------------------------------------------------------------------
module contiguous_page_run_allocator #(
   parameter int HEAP_ENTRIES  = cpra_pkg::HEAP_ENTRIES_DEF,
   parameter int FRAME_BITS    = cpra_pkg::FRAME_BITS_DEF,
   parameter int MAX_RUN_PAGES = cpra_pkg::MAX_RUN_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cpra_req_if.sink    req,
   cpra_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cpra_pkg::*;

   cfg_type     cfg;
   fs_cmd_type  fs_cmd;
   fs_stat_type fs_stat;
   logic [$clog2(FRAME_BITS/32)+4:0] frame_no;

   cpra_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cpra_frame_store #(.FRAME_BITS(FRAME_BITS)) u_frames (
      .clock       (clock),
      .reset       (reset),
      .cmd         (fs_cmd),
      .frame_count (cfg.frame_count),
      .stat        (fs_stat),
      .frame_no    (frame_no)
   );

   cpra_ctrl #(
      .HEAP_ENTRIES  (HEAP_ENTRIES),
      .FRAME_BITS    (FRAME_BITS),
      .MAX_RUN_PAGES (MAX_RUN_PAGES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req),
      .rsp      (rsp),
      .fs_cmd   (fs_cmd),
      .fs_stat  (fs_stat),
      .frame_no (frame_no)
   );

endmodule

// ===== rtl/cpra_csr.sv =====
// ----------------------------------------------------------------------------
// cpra_csr
// Configuration registers behind a small APB-style port.
// ----------------------------------------------------------------------------
module cpra_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cpra_pkg::cfg_type cfg
);
   import cpra_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[4:2])
            REG_ALLOC_BASE:   cfg_in.allocation_base  = pwdata;
            REG_USER_HEAP:    cfg_in.user_heap_active = pwdata[0];
            REG_HEAP_ENTRIES: cfg_in.heap_entries     = pwdata[12:0];
            REG_FRAME_COUNT:  cfg_in.frame_count      = pwdata[16:0];
            REG_FRAME_OFFSET: cfg_in.frame_offset     = pwdata[19:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_ALLOC_BASE:   prdata = cfg_ff.allocation_base;
         REG_USER_HEAP:    prdata = {31'd0, cfg_ff.user_heap_active};
         REG_HEAP_ENTRIES: prdata = {19'd0, cfg_ff.heap_entries};
         REG_FRAME_COUNT:  prdata = {15'd0, cfg_ff.frame_count};
         REG_FRAME_OFFSET: prdata = {12'd0, cfg_ff.frame_offset};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.allocation_base  <= RST_ALLOC_BASE;
         cfg_ff.user_heap_active <= 1'b0;
         cfg_ff.heap_entries     <= RST_HEAP_ENTRIES;
         cfg_ff.frame_count      <= RST_FRAME_COUNT;
         cfg_ff.frame_offset     <= 20'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/cpra_frame_store.sv =====
// ----------------------------------------------------------------------------
// cpra_frame_store
// Physical frame bitmap with a pointer to the lowest word that may hold a
// free frame; hands out the lowest free frame of that word.
// ----------------------------------------------------------------------------
module cpra_frame_store #(
   parameter int FRAME_BITS = cpra_pkg::FRAME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cpra_pkg::fs_cmd_type               cmd,
   input  logic [16:0]                        frame_count,
   output cpra_pkg::fs_stat_type              stat,
   output logic [$clog2(FRAME_BITS/32)+4:0]   frame_no
);
   import cpra_pkg::*;

   localparam int FW      = FRAME_BITS / 32;
   localparam int FW_IDX  = $clog2(FW);
   localparam int WORDS_W = $clog2(FW + 1);

   logic [31:0]        mem [FW];
   logic [31:0]        rdata_ff;
   logic [WORDS_W-1:0] ptr_ff, ptr_in;
   logic [FW_IDX-1:0]  clr_ff, clr_in;
   logic               clearing_ff, clearing_in;
   logic [WORDS_W-1:0] words;
   logic [11:0]        whole_words;
   logic [4:0]         bsel;

   assign whole_words = frame_count[16:5];
   assign words = (32'(whole_words) < 32'(FW)) ? WORDS_W'(whole_words) : WORDS_W'(FW);

   always_comb begin
      bsel = 5'd0;
      for (int b = 31; b >= 0; b--) begin
         if (!rdata_ff[b]) begin
            bsel = 5'(b);
         end
      end
   end

   assign stat.ready     = !clearing_ff;
   assign stat.full      = &rdata_ff;
   assign stat.exhausted = (ptr_ff >= words);
   assign frame_no       = {ptr_ff[FW_IDX-1:0], bsel};

   always_comb begin
      ptr_in      = cmd.skip ? WORDS_W'(ptr_ff + WORDS_W'(1)) : ptr_ff;
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = FW_IDX'(clr_ff + FW_IDX'(1));
         if (clr_ff == FW_IDX'(FW - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         ptr_ff      <= ptr_in;
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= 32'd0;
      end else if (cmd.take) begin
         mem[ptr_ff[FW_IDX-1:0]] <= rdata_ff | (32'd1 << bsel);
      end
      if (cmd.rd) begin
         rdata_ff <= mem[ptr_ff[FW_IDX-1:0]];
      end
   end

   a_take_not_full : assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !stat.full) else $error("frame taken from a full word");
   a_take_in_range : assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !stat.exhausted) else $error("frame taken beyond bitmap");
   a_idle_clearing : assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !cmd.take && !cmd.skip && !cmd.rd)
      else $error("bitmap used while clearing");

endmodule

// ===== rtl/cpra_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpra_ctrl
// Page table memory and the sequencer for allocate and free items.
// ----------------------------------------------------------------------------
module cpra_ctrl #(
   parameter int HEAP_ENTRIES  = cpra_pkg::HEAP_ENTRIES_DEF,
   parameter int FRAME_BITS    = cpra_pkg::FRAME_BITS_DEF,
   parameter int MAX_RUN_PAGES = cpra_pkg::MAX_RUN_PAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cpra_pkg::cfg_type                 cfg,
   cpra_req_if.sink                          req,
   cpra_rsp_if.source                        rsp,
   output cpra_pkg::fs_cmd_type              fs_cmd,
   input  cpra_pkg::fs_stat_type             fs_stat,
   input  logic [$clog2(FRAME_BITS/32)+4:0]  frame_no
);
   import cpra_pkg::*;

   localparam int HIDX  = $clog2(HEAP_ENTRIES);
   localparam int LIM_W = $clog2(HEAP_ENTRIES + 1);

   typedef enum logic [10:0] {
      S_CLEAR   = 11'b000_0000_0001,
      S_IDLE    = 11'b000_0000_0010,
      S_SCAN    = 11'b000_0000_0100,
      S_FRD     = 11'b000_0000_1000,
      S_FCHK    = 11'b000_0001_0000,
      S_FRLEN   = 11'b000_0010_0000,
      S_FRPAGE  = 11'b000_0100_0000,
      S_FRCHK   = 11'b000_1000_0000,
      S_EMIT    = 11'b001_0000_0000,
      S_SPARE_A = 11'b010_0000_0000,
      S_SPARE_B = 11'b100_0000_0000
   } state_type;

   logic [6:0] page_mem [HEAP_ENTRIES];
   logic [6:0] pg_rdata_ff;
   logic       pg_we, pg_re;
   logic [HIDX-1:0] pg_waddr, pg_raddr;
   logic [6:0] pg_wdata;

   state_type state_ff, state_in;
   logic [31:0]      addr_ff, addr_in;
   logic [6:0]       n_ff, n_in;
   logic [5:0]       k_ff, k_in;
   logic [5:0]       nsub_ff, nsub_in;
   logic [HIDX-1:0]  start_ff, start_in;
   logic [LIM_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [HIDX-1:0]  pidx_ff, pidx_in;
   logic [6:0]       run_ff, run_in;
   logic [HIDX-1:0]  e_ff, e_in;
   status_type       st_ff, st_in;
   logic [6:0]       freed_ff, freed_in;
   logic [HIDX-1:0]  clr_ff, clr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_va_ff, rsp_va_in;
   logic [31:0] rsp_pa_ff, rsp_pa_in;
   logic [5:0]  rsp_pir_ff, rsp_pir_in;
   logic [6:0]  rsp_freed_ff, rsp_freed_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [LIM_W-1:0] lim;
   logic             out_free;
   logic [31:0]      diff, sz_m1, page_a, page_d;
   logic [20:0]      n_req;
   logic [6:0]       run_n;
   logic [HIDX-1:0]  cur_e;
   logic [19:0]      pfn;
   status_type       page_st;

   assign lim = (32'(cfg.heap_entries) < 32'(HEAP_ENTRIES)) ?
                LIM_W'(cfg.heap_entries) : LIM_W'(HEAP_ENTRIES);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign diff     = req.address - cfg.allocation_base;
   assign sz_m1    = req.size_bytes - 32'd1;
   assign n_req    = (req.size_bytes <= PAGE_BYTES) ? 21'd1 :
                     21'(21'(sz_m1[31:12]) + 21'd1);
   assign run_n    = pg_rdata_ff[6] ? 7'd0 : 7'(run_ff + 7'd1);
   assign cur_e    = HIDX'(start_ff + HIDX'(k_ff));
   assign pfn      = 20'(20'(frame_no) + cfg.frame_offset);
   assign page_a   = addr_ff + (32'(k_ff) << 12);
   assign page_d   = page_a - cfg.allocation_base;

   always_comb begin
      if (page_a == 32'd0) begin
         page_st = ST_NULL;
      end else if (page_a >= KERNEL_LIMIT) begin
         page_st = ST_KERNEL;
      end else if (cfg.user_heap_active && page_a >= KERNEL_HEAP_LOW) begin
         page_st = ST_WRONG_HEAP;
      end else if (!cfg.user_heap_active && page_a < KERNEL_HEAP_LOW) begin
         page_st = ST_NO_USER_HEAP;
      end else begin
         page_st = ST_OK;
      end
   end

   assign req.ready           = (state_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.virtual_address = rsp_va_ff;
   assign rsp.phys_address    = rsp_pa_ff;
   assign rsp.page_in_run     = rsp_pir_ff;
   assign rsp.pages_freed     = rsp_freed_ff;
   assign rsp.last            = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      nsub_in  = nsub_ff;
      start_in = start_ff;
      scan_in  = scan_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      run_in   = run_ff;
      e_in     = e_ff;
      st_in    = st_ff;
      freed_in = freed_ff;
      clr_in   = clr_ff;
      pg_we    = 1'b0;
      pg_waddr = cur_e;
      pg_wdata = 7'd0;
      pg_re    = 1'b0;
      pg_raddr = e_ff;
      fs_cmd   = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_va_in     = rsp_va_ff;
      rsp_pa_in     = rsp_pa_ff;
      rsp_pir_in    = rsp_pir_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_CLEAR: begin
            pg_we    = 1'b1;
            pg_waddr = clr_ff;
            if (clr_ff == HIDX'(HEAP_ENTRIES - 1)) begin
               if (fs_stat.ready) begin
                  state_in = S_IDLE;
               end
            end else begin
               clr_in = HIDX'(clr_ff + HIDX'(1));
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               addr_in  = req.address;
               k_in     = 6'd0;
               freed_in = 7'd0;
               st_in    = ST_OK;
               run_in   = 7'd0;
               scan_in  = '0;
               n_in     = n_req[6:0];
               if (!req.kind) begin
                  if (n_req > 21'(MAX_RUN_PAGES)) begin
                     st_in    = ST_TOO_LARGE;
                     state_in = S_EMIT;
                  end else if (lim == '0) begin
                     st_in    = ST_NO_RUN;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (req.address == 32'd0) begin
                  st_in    = ST_NULL;
                  state_in = S_EMIT;
               end else if (diff[31:12] >= 20'(lim)) begin
                  st_in    = ST_RANGE;
                  state_in = S_EMIT;
               end else begin
                  pg_re    = 1'b1;
                  pg_raddr = diff[HIDX+11:12];
                  state_in = S_FRLEN;
               end
            end
         end
         S_SCAN: begin
            if (scan_ff < lim) begin
               pg_re    = 1'b1;
               pg_raddr = scan_ff[HIDX-1:0];
               scan_in  = LIM_W'(scan_ff + LIM_W'(1));
               pend_in  = 1'b1;
               pidx_in  = scan_ff[HIDX-1:0];
            end
            if (pend_ff) begin
               run_in = run_n;
               if (run_n == n_ff) begin
                  start_in = HIDX'(pidx_ff + HIDX'(1) - HIDX'(n_ff));
                  state_in = S_FRD;
               end else if (LIM_W'(LIM_W'(pidx_ff) + LIM_W'(1)) == lim) begin
                  st_in    = ST_NO_RUN;
                  state_in = S_EMIT;
               end
            end
         end
         S_FRD: begin
            if (fs_stat.exhausted) begin
               pg_we    = 1'b1;
               pg_waddr = start_ff;
               pg_wdata = {(k_ff != 6'd0), 6'(n_ff - 7'd1)};
               st_in    = ST_NO_FRAME;
               freed_in = 7'd0;
               state_in = S_EMIT;
            end else begin
               fs_cmd.rd = 1'b1;
               state_in  = S_FCHK;
            end
         end
         S_FCHK: begin
            if (fs_stat.full) begin
               fs_cmd.skip = 1'b1;
               state_in    = S_FRD;
            end else if (out_free) begin
               fs_cmd.take   = 1'b1;
               pg_we         = 1'b1;
               pg_waddr      = cur_e;
               pg_wdata      = (k_ff == 6'd0) ? {1'b1, 6'(n_ff - 7'd1)} : 7'b100_0000;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_va_in     = cfg.allocation_base + (32'(cur_e) << 12);
               rsp_pa_in     = {pfn, 12'h000};
               rsp_pir_in    = k_ff;
               rsp_freed_in  = 7'd0;
               rsp_last_in   = (7'(k_ff) + 7'd1 == n_ff);
               if (7'(k_ff) + 7'd1 == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = 6'(k_ff + 6'd1);
                  state_in = S_FRD;
               end
            end
         end
         S_FRLEN: begin
            nsub_in  = pg_rdata_ff[5:0];
            state_in = S_FRPAGE;
         end
         S_FRPAGE: begin
            if (page_st != ST_OK) begin
               if (k_ff == 6'd0) begin
                  st_in = page_st;
               end
               if (k_ff == nsub_ff) begin
                  state_in = S_EMIT;
               end else begin
                  k_in = 6'(k_ff + 6'd1);
               end
            end else if (page_d[31:12] >= 20'(lim)) begin
               state_in = S_EMIT;
            end else begin
               pg_re    = 1'b1;
               pg_raddr = page_d[HIDX+11:12];
               e_in     = page_d[HIDX+11:12];
               state_in = S_FRCHK;
            end
         end
         S_FRCHK: begin
            if (pg_rdata_ff[6]) begin
               pg_we    = 1'b1;
               pg_waddr = e_ff;
               pg_wdata = 7'd0;
               freed_in = 7'(freed_ff + 7'd1);
            end else if (k_ff == 6'd0) begin
               st_in = ST_NOT_PRESENT;
            end
            if (k_ff == nsub_ff) begin
               state_in = S_EMIT;
            end else begin
               k_in     = 6'(k_ff + 6'd1);
               state_in = S_FRPAGE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_va_in     = 32'd0;
               rsp_pa_in     = 32'd0;
               rsp_pir_in    = 6'd0;
               rsp_freed_in  = freed_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      nsub_ff       <= nsub_in;
      start_ff      <= start_in;
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      run_ff        <= run_in;
      e_ff          <= e_in;
      st_ff         <= st_in;
      freed_ff      <= freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_va_ff     <= rsp_va_in;
      rsp_pa_ff     <= rsp_pa_in;
      rsp_pir_ff    <= rsp_pir_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (pg_we) begin
         page_mem[pg_waddr] <= pg_wdata;
      end
      if (pg_re) begin
         pg_rdata_ff <= page_mem[pg_raddr];
      end
   end

   a_fail_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_NO_FRAME || rsp_status_ff == ST_NO_RUN)
      |-> rsp_last_ff) else $error("failure beat not marked last");
   a_quiet_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff && !req.ready)
      else $error("traffic during clearing pass");
   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      pg_we && pg_re |-> pg_waddr != pg_raddr)
      else $error("page entry read and written together");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the contiguous page-run allocator.
//
// A table of directed beats and register writes covers the size extremes,
// every status and the wrap, kernel, heap-end and frame-exhaustion cases.
// Several register settings with randomised allocate and free traffic follow.
// A predictor holds its own copy of the present bits, run lengths and frame
// bitmap; every response beat is compared with the oldest prediction while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import cpra_pkg::*;

   typedef enum logic [1:0] {ROW_ALLOC, ROW_FREE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0]  value;
      logic [31:0]  data;
      bit           typed;
      status_type   status;
   } stim_row_type;

   typedef struct {
      status_type  status;
      logic [31:0] virtual_address;
      logic [31:0] phys_address;
      logic [5:0]  page_in_run;
      logic [6:0]  pages_freed;
      logic        last;
   } page_beat_type;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 24;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   cpra_req_if req ();
   cpra_rsp_if rsp ();

   contiguous_page_run_allocator DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [31:0] heap_base;
   logic        user_heap;
   logic [12:0] entry_count;
   logic [16:0] frame_total;
   logic [19:0] frame_base;
   bit          page_present [HEAP_ENTRIES_DEF];
   logic [5:0]  run_pages [HEAP_ENTRIES_DEF];
   logic [31:0] frame_words [FRAME_BITS_DEF / 32];

   page_beat_type owed_beats[$];
   logic [31:0]   run_starts[$];
   int            errors;
   bit            no_idle;
   stim_row_type  directed[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("contiguous_page_run_allocator verification failed");
            $finish;
         end
      end
   end

   function automatic int unsigned heap_limit();
      return (entry_count < HEAP_ENTRIES_DEF) ? entry_count : HEAP_ENTRIES_DEF;
   endfunction

   function automatic void owe(status_type st, logic [31:0] va, logic [31:0] pa,
                               logic [5:0] pos, logic [6:0] freed, logic last);
      page_beat_type b;
      b.status = st;
      b.virtual_address = va;
      b.phys_address = pa;
      b.page_in_run = pos;
      b.pages_freed = freed;
      b.last = last;
      owed_beats.push_back(b);
   endfunction

   function automatic bit grab_frame(output logic [31:0] frame);
      int unsigned words;
      words = frame_total >> 5;
      if (words > FRAME_BITS_DEF / 32) words = FRAME_BITS_DEF / 32;
      for (int unsigned w = 0; w < words; w++) begin
         for (int unsigned b = 0; b < 32; b++) begin
            if (!frame_words[w][b]) begin
               frame_words[w][b] = 1'b1;
               frame = w * 32 + b;
               return 1'b1;
            end
         end
      end
      frame = 0;
      return 1'b0;
   endfunction

   function automatic void allocate_run(logic [31:0] size);
      int unsigned pages, lim, run, start, e;
      bit found;
      logic [31:0] frame;
      logic [31:0] va;
      pages = (size <= PAGE_BYTES) ? 1 : ((size - 1) >> 12) + 1;
      lim = heap_limit();
      run = 0;
      start = 0;
      found = 1'b0;
      if (pages > MAX_RUN_PAGES_DEF) begin
         owe(ST_TOO_LARGE, 0, 0, 0, 0, 1'b1);
         return;
      end
      for (int unsigned i = 0; i < lim && !found; i++) begin
         run = page_present[i] ? 0 : run + 1;
         if (run == pages) begin
            start = i + 1 - pages;
            found = 1'b1;
         end
      end
      if (!found) begin
         owe(ST_NO_RUN, 0, 0, 0, 0, 1'b1);
         return;
      end
      for (int unsigned k = 0; k < pages; k++) begin
         e = start + k;
         if (!grab_frame(frame)) begin
            run_pages[start] = 6'(pages - 1);
            owe(ST_NO_FRAME, 0, 0, 0, 0, 1'b1);
            return;
         end
         page_present[e] = 1'b1;
         run_pages[e] = 0;
         va = heap_base + (32'(e) << 12);
         if (k == 0) run_starts.push_back(va);
         owe(ST_OK, va, {20'(frame + frame_base), 12'h000}, 6'(k), 0,
             k + 1 == pages);
      end
      run_pages[start] = 6'(pages - 1);
   endfunction

   function automatic void free_run(logic [31:0] address);
      int unsigned lim, span, freed;
      logic [31:0] first, a, e;
      status_type st, first_status;
      lim = heap_limit();
      first = (address - heap_base) >> 12;
      freed = 0;
      first_status = ST_OK;
      if (address == 0) begin
         owe(ST_NULL, 0, 0, 0, 0, 1'b1);
         return;
      end
      if (first >= lim) begin
         owe(ST_RANGE, 0, 0, 0, 0, 1'b1);
         return;
      end
      span = run_pages[first];
      for (int unsigned k = 0; k <= span; k++) begin
         a = address + 32'(k) * PAGE_BYTES;
         st = ST_OK;
         if (a == 0) st = ST_NULL;
         else if (a >= KERNEL_LIMIT) st = ST_KERNEL;
         else if (user_heap && a >= KERNEL_HEAP_LOW) st = ST_WRONG_HEAP;
         else if (!user_heap && a < KERNEL_HEAP_LOW) st = ST_NO_USER_HEAP;
         if (st == ST_OK) begin
            e = (a - heap_base) >> 12;
            if (e >= lim) break;
            if (page_present[e]) begin
               page_present[e] = 1'b0;
               run_pages[e] = 0;
               freed++;
            end else begin
               st = ST_NOT_PRESENT;
            end
         end
         if (k == 0) first_status = st;
      end
      owe(first_status, 0, 0, 0, 7'(freed), 1'b1);
   endfunction

   task automatic drain();
      req.valid <= 1'b0;
      while (owed_beats.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] v);
      drain();
      repeat (8) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ALLOC_BASE: begin
            heap_base = v;
            run_starts.delete();
         end
         REG_USER_HEAP: user_heap = v[0];
         REG_HEAP_ENTRIES: entry_count = v[12:0];
         REG_FRAME_COUNT: frame_total = v[16:0];
         REG_FRAME_OFFSET: frame_base = v[19:0];
         default: ;
      endcase
   endtask

   task automatic send(logic kind, logic [31:0] size, logic [31:0] address,
                       bit typed = 1'b0, status_type st = ST_OK);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= kind;
      req.size_bytes <= size;
      req.address <= address;
      do @(posedge clock); while (!req.ready);
      if (kind) free_run(address);
      else allocate_run(size);
      if (typed) owed_beats[$].status = st;
   endtask

   // Response side: random stalls, and every beat checked against the oldest prediction.
   initial begin
      int unsigned stall;
      page_beat_type want;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 18);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         if (owed_beats.size() == 0) begin
            $error("response beat with nothing outstanding, status %0d", rsp.status);
            errors++;
         end else begin
            want = owed_beats.pop_front();
            if (rsp.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp.status);
               errors++;
            end
            if (rsp.virtual_address !== want.virtual_address) begin
               $error("virtual_address expected %h got %h",
                      want.virtual_address, rsp.virtual_address);
               errors++;
            end
            if (rsp.phys_address !== want.phys_address) begin
               $error("phys_address expected %h got %h",
                      want.phys_address, rsp.phys_address);
               errors++;
            end
            if (rsp.page_in_run !== want.page_in_run) begin
               $error("page_in_run expected %0d got %0d",
                      want.page_in_run, rsp.page_in_run);
               errors++;
            end
            if (rsp.pages_freed !== want.pages_freed) begin
               $error("pages_freed expected %0d got %0d",
                      want.pages_freed, rsp.pages_freed);
               errors++;
            end
            if (rsp.last !== want.last) begin
               $error("last expected %0d got %0d", want.last, rsp.last);
               errors++;
            end
         end
      end
   end

   function automatic void row(row_kind_type k, logic [31:0] v, logic [31:0] d = 0,
                               bit typed = 1'b0, status_type st = ST_OK);
      stim_row_type r;
      r.kind = k;
      r.value = v;
      r.data = d;
      r.typed = typed;
      r.status = st;
      directed.push_back(r);
   endfunction

   initial begin
      logic [31:0] addr;
      logic [31:0] size;
      int unsigned pick;
      errors = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.kind <= 1'b0;
      req.size_bytes <= '0;
      req.address <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      heap_base = RST_ALLOC_BASE;
      user_heap = 1'b0;
      entry_count = RST_HEAP_ENTRIES;
      frame_total = RST_FRAME_COUNT;
      frame_base = '0;
      foreach (page_present[i]) page_present[i] = 1'b0;
      foreach (run_pages[i]) run_pages[i] = '0;
      foreach (frame_words[i]) frame_words[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      row(ROW_ALLOC, 32'h0);
      row(ROW_ALLOC, 32'h1);
      row(ROW_ALLOC, 32'h1000);
      row(ROW_ALLOC, 32'h1001);
      row(ROW_ALLOC, 32'hFFFF_FFFF, 0, 1'b1, ST_TOO_LARGE);
      row(ROW_ALLOC, 32'h0004_0001, 0, 1'b1, ST_TOO_LARGE);
      row(ROW_ALLOC, 32'h0004_0000);
      row(ROW_FREE, 32'h0, 0, 1'b1, ST_NULL);
      row(ROW_FREE, 32'h7FFF_F000, 0, 1'b1, ST_RANGE);
      row(ROW_FREE, 32'h8000_0000);
      row(ROW_FREE, 32'h8000_0000, 0, 1'b1, ST_NOT_PRESENT);
      row(ROW_FREE, 32'h8000_3000);
      row(ROW_FREE, 32'h80FF_F000, 0, 1'b1, ST_NOT_PRESENT);
      row(ROW_FREE, 32'h8100_0000, 0, 1'b1, ST_RANGE);
      row(ROW_ALLOC, 32'h2000);
      row(ROW_WRITE, REG_ALLOC_BASE, 32'hBFFF_E000);
      row(ROW_WRITE, REG_USER_HEAP, 32'h1);
      row(ROW_FREE, 32'hC000_0000, 0, 1'b1, ST_KERNEL);
      row(ROW_FREE, 32'hBFFF_F000, 0, 1'b1, ST_WRONG_HEAP);
      row(ROW_WRITE, REG_ALLOC_BASE, 32'h7FFF_E000);
      row(ROW_WRITE, REG_USER_HEAP, 32'h0);
      row(ROW_FREE, 32'h7FFF_F000, 0, 1'b1, ST_NO_USER_HEAP);
      row(ROW_WRITE, REG_FRAME_COUNT, 32'd31);
      row(ROW_ALLOC, 32'h1, 0, 1'b1, ST_NO_FRAME);
      row(ROW_WRITE, REG_HEAP_ENTRIES, 32'd0);
      row(ROW_ALLOC, 32'h1, 0, 1'b1, ST_NO_RUN);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_WRITE)
            write_reg(reg_index_type'(directed[i].value[2:0]), directed[i].data);
         else
            send(directed[i].kind == ROW_FREE, directed[i].value, directed[i].value,
                 directed[i].typed, directed[i].status);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               write_reg(REG_ALLOC_BASE, 32'hBFFF_0000);
               write_reg(REG_USER_HEAP, 32'h1);
               write_reg(REG_HEAP_ENTRIES, 32'd40);
               write_reg(REG_FRAME_COUNT, 32'd4096);
               write_reg(REG_FRAME_OFFSET, 32'hF_FFFF);
            end
            1: begin
               write_reg(REG_ALLOC_BASE, 32'h7FFF_8000);
               write_reg(REG_USER_HEAP, 32'h0);
               write_reg(REG_HEAP_ENTRIES, 32'd64);
               write_reg(REG_FRAME_COUNT, 32'd8191);
               write_reg(REG_FRAME_OFFSET, 32'd0);
            end
            2: begin
               write_reg(REG_ALLOC_BASE, 32'hFFFF_C000);
               write_reg(REG_HEAP_ENTRIES, 32'd8);
               write_reg(REG_FRAME_COUNT, 32'd65536);
               write_reg(REG_FRAME_OFFSET, 32'd12345);
            end
            3: begin
               write_reg(REG_ALLOC_BASE, 32'h0000_0000);
               write_reg(REG_USER_HEAP, 32'h1);
               write_reg(REG_HEAP_ENTRIES, 32'd8191);
               write_reg(REG_FRAME_COUNT, 32'h1_FFFF);
            end
            4: begin
               write_reg(REG_ALLOC_BASE, 32'h4000_0000);
               write_reg(REG_HEAP_ENTRIES, 32'd100);
               write_reg(REG_FRAME_COUNT, 32'd2100);
               write_reg(REG_FRAME_OFFSET, 32'hF_FFF0);
            end
            default: begin
               write_reg(REG_ALLOC_BASE, $urandom);
               write_reg(REG_USER_HEAP, $urandom_range(0, 1));
               write_reg(REG_HEAP_ENTRIES, $urandom_range(1, 300));
               write_reg(REG_FRAME_COUNT, 32'h1_0000);
               write_reg(REG_FRAME_OFFSET, $urandom);
            end
         endcase
         no_idle = (p % 3 == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == PHASE_ITEMS / 2) drain();
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               pick = $urandom_range(0, 99);
               if (pick < 75) size = $urandom_range(1, 8 * 4096);
               else if (pick < 90) size = $urandom_range(0, 32'h0004_2000);
               else size = $urandom;
               send(1'b0, size, $urandom);
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 55 && run_starts.size() != 0) begin
                  pick = $urandom_range(0, run_starts.size() - 1);
                  addr = run_starts[pick];
                  run_starts.delete(pick);
               end else if (pick < 80) begin
                  addr = heap_base + ($urandom_range(0, heap_limit() + 2) << 12);
               end else if (pick < 90) begin
                  addr = heap_base + $urandom_range(0, 32'h3FFFF);
               end else begin
                  addr = $urandom;
               end
               send(1'b1, $urandom, addr);
            end
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && owed_beats.size() == 0)
         $display("contiguous_page_run_allocator verification clean");
      else
         $display("contiguous_page_run_allocator verification failed");
      $finish;
   end

endmodule
